// ----- sv/motion_detect_ema_unit_defines.svh -----
// Assertion macros shared by the checker of the motion detector.
// No dependencies; the checker pulls this header in by name.
`ifndef MOTION_DETECT_EMA_UNIT_DEFINES_SVH
`define MOTION_DETECT_EMA_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and quiet while reset is high.
`define MDE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("motion detector check failed");

// Next-cycle implication, sampled on clock and quiet while reset is high.
`define MDE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("motion detector check failed");

`endif

// ----- sv/mde_pkg.sv -----
// Shared types and constants of the motion detector: field widths, register
// indexes, the sequencer states and the per-axis lane control group. No dependencies.
package mde_pkg;

   localparam int AXES       = 3;
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 17;
   localparam int THRESH_W   = 17;
   localparam int INTERVAL_W = 8;
   localparam int COUNT_W    = 8;
   localparam int AVG_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int PROD_A_W   = GAIN_W + 1 + SAMPLE_W;
   localparam int PROD_B_W   = GAIN_W + 1 + AVG_W;
   localparam int DIFF_W     = AVG_W + 1;
   localparam int ABS_W      = 24;
   localparam int SQ_W       = 2 * ABS_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int MAG_W      = 17;
   localparam int MAG_SHIFT  = 8;
   localparam int STEP_W     = $clog2(ROOT_W);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]     GAIN_ONE       = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = GAIN_W'(6554);
   localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(1000);
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = '0;

   // Register index, taken from paddr[3:2].
   localparam logic [1:0] REG_GAIN     = 2'd0;
   localparam logic [1:0] REG_THRESH   = 2'd1;
   localparam logic [1:0] REG_INTERVAL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_DIFF,
      ST_SQR,
      ST_SUM,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic load;
      logic mul;
      logic upd;
      logic ref_copy;
      logic diff;
      logic sqr;
   } lane_ctrl_type;

endpackage

// ----- sv/motion_detect_ema_unit.sv -----
// Top level of the three-axis moving-average motion detector.
// Depends on mde_pkg, mde_lane and mde_isqrt.
//
// Usage:
//   Requests arrive on the req_ stream: req_tdata carries one accelerometer
//   sample (X, Y, Z, 16 bits each). Every request yields exactly one response
//   on the rsp_ stream: rsp_tuser flags detected motion and rsp_tdata carries
//   the magnitude in sample units (zero when nothing was detected).
//   Three lanes, one per axis, keep a Q16.16 moving average and a reference
//   vector and square their deviation; a merging stage adds the three squares
//   and takes a 25-step, two-bits-per-cycle square root.
// Request flow:
//   One request is in flight at a time. The first request after reset or
//   re-arm goes from MUL straight to EMIT, a settling or skipped request
//   passes MUL, UPD and EMIT, and a checked request MUL, UPD, DIFF, SQR,
//   SUM, ROOT and EMIT, the square root loop being its longest part. EMIT
//   loads the output register once that register is free.
// Stalls and reset:
//   The response register parts the two sides, so a new request is accepted
//   while a response waits; a second finished response waits in the
//   sequencer until the register frees up. Synchronous reset clears the
//   counters, the averages and the registers to their reset values.
//   Configuration goes through the csr_ port and must be written only while idle; the block does not enforce this.
module motion_detect_ema_unit
   import mde_pkg::*;
#(
   parameter int SETTLE_ITEMS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // motion_magnitude [16:0], zero fill [23:17]
   output logic                  rsp_tuser,   // motion_found [0]
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [COUNT_W-1:0] SETTLE_LIMIT = COUNT_W'(SETTLE_ITEMS);

   // Configuration registers.
   logic [GAIN_W-1:0]     gain_ff;
   logic [GAIN_W-1:0]     gain_in;
   logic [THRESH_W-1:0]   thresh_ff;
   logic [THRESH_W-1:0]   thresh_in;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [INTERVAL_W-1:0] interval_in;
   logic                  csr_write;
   logic [1:0]            csr_index;

   // Sequencer and detector state.
   state_type             state_ff;
   state_type             state_in;
   logic [COUNT_W-1:0]    settle_ff;
   logic [COUNT_W-1:0]    settle_in;
   logic [COUNT_W-1:0]    skip_ff;
   logic [COUNT_W-1:0]    skip_in;
   logic                  found_ff;
   logic                  found_in;
   logic [MAG_W-1:0]      mag_ff;
   logic [MAG_W-1:0]      mag_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_found_ff;
   logic                  rsp_found_in;
   logic [MAG_W-1:0]      rsp_mag_ff;
   logic [MAG_W-1:0]      rsp_mag_in;

   // Datapath hookup.
   lane_ctrl_type             lane_ctrl;
   logic [GAIN_W-1:0]         gain_eff;
   logic [GAIN_W-1:0]         gain_rest;
   logic [AXES-1:0][SQ_W-1:0] squares;
   logic                      root_start;
   logic                      root_done;
   logic [ROOT_W-1:0]         root;
   logic [MAG_W-1:0]          root_mag;
   logic                      req_take;
   logic                      rsp_free;

   // ------------------------------------------------------------------
   // Configuration port. A gain above one is treated as exactly one.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      gain_in     = gain_ff;
      thresh_in   = thresh_ff;
      interval_in = interval_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GAIN:     gain_in     = csr_pwdata[GAIN_W-1:0];
            REG_THRESH:   thresh_in   = csr_pwdata[THRESH_W-1:0];
            REG_INTERVAL: interval_in = csr_pwdata[INTERVAL_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GAIN:     csr_prdata = CSR_DATA_W'(gain_ff);
         REG_THRESH:   csr_prdata = CSR_DATA_W'(thresh_ff);
         REG_INTERVAL: csr_prdata = CSR_DATA_W'(interval_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign gain_eff  = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
   assign gain_rest = GAIN_ONE - gain_eff;

   // ------------------------------------------------------------------
   // Axis lanes and the merging square-root stage.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < AXES; i++) begin : g_lane
      mde_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .sample    ($signed(req_tdata[i*SAMPLE_W +: SAMPLE_W])),
         .gain      (gain_eff),
         .gain_rest (gain_rest),
         .square    (squares[i])
      );
   end

   mde_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .squares (squares),
      .done    (root_done),
      .root    (root)
   );

   assign root_mag = root[MAG_SHIFT +: MAG_W];

   // ------------------------------------------------------------------
   // Sequencer. One request at a time walks through the states; the
   // decisions on settling, skipping and re-arming are made here.
   // ------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      settle_in    = settle_ff;
      skip_in      = skip_ff;
      found_in     = found_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_mag_in   = rsp_mag_ff;
      lane_ctrl    = '0;
      root_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               lane_ctrl.take = 1'b1;
               found_in       = 1'b0;
               mag_in         = '0;
               state_in       = ST_MUL;
            end
         end
         ST_MUL: begin
            if (settle_ff == '0) begin
               // First sample after reset or re-arm seeds the average.
               lane_ctrl.load = 1'b1;
               settle_in      = COUNT_W'(1);
               state_in       = ST_EMIT;
            end else begin
               lane_ctrl.mul = 1'b1;
               state_in      = ST_UPD;
            end
         end
         ST_UPD: begin
            lane_ctrl.upd = 1'b1;
            if (settle_ff < SETTLE_LIMIT) begin
               lane_ctrl.ref_copy = 1'b1;
               settle_in          = settle_ff + COUNT_W'(1);
               state_in           = ST_EMIT;
            end else if (skip_ff < interval_ff) begin
               skip_in  = skip_ff + COUNT_W'(1);
               state_in = ST_EMIT;
            end else begin
               skip_in  = '0;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            lane_ctrl.diff = 1'b1;
            state_in       = ST_SQR;
         end
         ST_SQR: begin
            lane_ctrl.sqr = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               if (root_mag > thresh_ff) begin
                  // Motion: report and re-arm. The skip counter keeps its value.
                  found_in  = 1'b1;
                  mag_in    = root_mag;
                  settle_in = '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_mag_in   = mag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         settle_ff    <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         thresh_ff    <= THRESH_RESET;
         interval_ff  <= INTERVAL_RESET;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         thresh_ff    <= thresh_in;
         interval_ff  <= interval_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      mag_ff       <= mag_in;
      rsp_found_ff <= rsp_found_in;
      rsp_mag_ff   <= rsp_mag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = 24'(rsp_mag_ff);

endmodule

// ----- sv/mde_lane.sv -----
// One axis lane: moving-average state, reference copy and squared deviation.
// Depends on mde_pkg for widths and the lane control struct.
module mde_lane
   import mde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [GAIN_W-1:0]          gain,
   input  logic [GAIN_W-1:0]          gain_rest,
   output logic [SQ_W-1:0]            square
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [AVG_W-1:0]    avg_ff;
   logic signed [AVG_W-1:0]    ref_ff;
   logic signed [PROD_A_W-1:0] prod_a_ff;
   logic signed [PROD_A_W-1:0] prod_a_in;
   logic signed [PROD_B_W-1:0] prod_b_ff;
   logic signed [PROD_B_W-1:0] prod_b_in;
   logic signed [PROD_B_W-1:0] upd_sum;
   logic [AVG_W-1:0]           avg_upd;
   logic [DIFF_W-1:0]          diff;
   logic [DIFF_W-1:0]          diff_abs;
   logic [ABS_W-1:0]           abs_ff;
   logic [ABS_W-1:0]           abs_in;
   logic [SQ_W-1:0]            sq_ff;
   logic [SQ_W-1:0]            sq_in;

   always_comb begin
      prod_a_in = $signed({1'b0, gain}) * sample_ff;
      prod_b_in = $signed({1'b0, gain_rest}) * avg_ff;
      // The new-sample term has no fraction, so flooring the sum only
      // touches the weighted old average.
      upd_sum   = (prod_b_ff >>> FRAC_W) + prod_a_ff;
      avg_upd   = upd_sum[AVG_W-1:0];
      diff      = {avg_ff[AVG_W-1], avg_ff} - {ref_ff[AVG_W-1], ref_ff};
      diff_abs  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      abs_in    = diff_abs[MAG_SHIFT +: ABS_W];
      sq_in     = abs_ff * abs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
         ref_ff <= '0;
      end else begin
         if (ctrl.load) begin
            avg_ff <= {sample_ff, {FRAC_W{1'b0}}};
         end else if (ctrl.upd) begin
            avg_ff <= avg_upd;
         end
         if (ctrl.upd && ctrl.ref_copy) begin
            ref_ff <= avg_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         sample_ff <= sample;
      end
      if (ctrl.mul) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (ctrl.diff) begin
         abs_ff <= abs_in;
      end
      if (ctrl.sqr) begin
         sq_ff <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule

// ----- sv/mde_isqrt.sv -----
// Merging stage: sums the lanes' squared deviations and takes the floor
// square root two bits per cycle. Depends on mde_pkg for widths.
module mde_isqrt
   import mde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [AXES-1:0][SQ_W-1:0]  squares,
   output logic                       done,
   output logic [ROOT_W-1:0]          root
);

   logic [SUM_W-1:0]  op_ff;
   logic [SUM_W-1:0]  op_in;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W-1:0] root_in;
   logic [STEP_W-1:0] count_ff;
   logic [STEP_W-1:0] count_in;
   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;
   logic [REM_W-1:0]  cand;
   logic [REM_W-1:0]  trial;
   logic [SUM_W-1:0]  total;

   always_comb begin
      total = '0;
      for (int i = 0; i < AXES; i++) begin
         total = total + SUM_W'(squares[i]);
      end
      cand  = {rem_ff[REM_W-3:0], op_ff[SUM_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};

      op_in    = op_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         op_in    = total;
         rem_in   = '0;
         root_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         op_in = {op_ff[SUM_W-3:0], 2'b00};
         if (cand >= trial) begin
            rem_in  = cand - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cand;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         count_in = count_ff + STEP_W'(1);
         if (count_ff == STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- sv/mde_checker.sv -----
// Port-level checker for the motion detector, bound to the top level.
// Depends on motion_detect_ema_unit_defines.svh for the assertion macros.
`include "motion_detect_ema_unit_defines.svh"

module mde_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled response stays valid and keeps its payload.
   `MDE_ASSERT_NEXT(a_rsp_hold_valid, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `MDE_ASSERT_NEXT(a_rsp_hold_data, rsp_tvalid && !rsp_tready, $stable({rsp_tuser, rsp_tdata}))

   // Only one request is worked on at a time.
   `MDE_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)

   // Without a detection the magnitude reads as zero.
   `MDE_ASSERT_NOW(a_quiet_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 24'd0)

   // A detection always carries a magnitude above some threshold, so never zero.
   `MDE_ASSERT_NOW(a_found_nonzero, rsp_tvalid && rsp_tuser, rsp_tdata != 24'd0)

endmodule

bind motion_detect_ema_unit mde_port_checker u_mde_checker (.*);

// ----- test/mde_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard of the motion detector: mirrors the registers from the csr_ port,
// predicts one motion report per accepted request and compares every response.
// Depends on mde_pkg only.
module mde_checker
   import mde_pkg::*;
#(
   parameter int SETTLE_ITEMS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,   // motion_magnitude [16:0], zero fill [23:17]
   input  logic                  rsp_tuser,   // motion_found [0]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    reports_pending,
   output int                    mismatch_count,
   output int                    samples_seen,
   output int                    motion_events
);

   typedef struct packed {
      logic             found;
      logic [MAG_W-1:0] magnitude;
   } motion_report_type;

   logic [GAIN_W-1:0]       gain_reg;
   logic [THRESH_W-1:0]     thresh_reg;
   logic [INTERVAL_W-1:0]   interval_reg;
   logic [COUNT_W-1:0]      settle_cnt;
   logic [COUNT_W-1:0]      skip_cnt;
   logic signed [AVG_W-1:0] average_q [AXES];
   logic signed [AVG_W-1:0] reference_q [AXES];
   motion_report_type       reports_due [$];

   // Floor of the square root, one result bit per pass from the top down.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned c;
      int              b;
      r = 0;
      for (b = 25; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= n) r = c;
      end
      return r;
   endfunction

   // Advances the detector state by one sample and returns its report.
   function automatic motion_report_type advance_detector(input logic [47:0] sample);
      motion_report_type rep;
      longint signed     weight;
      longint signed     axis_val;
      longint signed     avg_val;
      longint signed     blend;
      longint signed     dev;
      longint unsigned   dev_q8;
      longint unsigned   sq_sum;
      longint unsigned   root;
      int                a;
      rep = '0;
      weight = longint'(gain_reg);
      if (gain_reg > GAIN_ONE) weight = 65536;

      if (settle_cnt == 0) begin
         for (a = 0; a < AXES; a++) average_q[a] = {sample[16*a +: 16], 16'h0000};
         settle_cnt = COUNT_W'(1);
         return rep;
      end

      // Weighted blend in Q16.32, rounded toward minus infinity to Q16.16.
      for (a = 0; a < AXES; a++) begin
         axis_val = $signed(sample[16*a +: 16]);
         avg_val = average_q[a];
         blend = weight * (axis_val * 65536) + (65536 - weight) * avg_val;
         blend = blend >>> FRAC_W;
         average_q[a] = blend[AVG_W-1:0];
      end

      if (settle_cnt < SETTLE_ITEMS) begin
         for (a = 0; a < AXES; a++) reference_q[a] = average_q[a];
         settle_cnt = settle_cnt + COUNT_W'(1);
         return rep;
      end

      if (skip_cnt < interval_reg) begin
         skip_cnt = skip_cnt + COUNT_W'(1);
         return rep;
      end
      skip_cnt = '0;

      sq_sum = 0;
      for (a = 0; a < AXES; a++) begin
         avg_val = average_q[a];
         dev = avg_val - longint'(reference_q[a]);
         if (dev < 0) dev = -dev;
         dev_q8 = dev >> 8;
         sq_sum += dev_q8 * dev_q8;
      end
      root = floor_sqrt(sq_sum) >> MAG_SHIFT;

      if (root > thresh_reg) begin
         settle_cnt = '0;
         rep.found = 1'b1;
         rep.magnitude = root[MAG_W-1:0];
      end
      return rep;
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s differs, expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      motion_report_type due;
      int                a;
      if (reset) begin
         gain_reg = GAIN_RESET;
         thresh_reg = THRESH_RESET;
         interval_reg = INTERVAL_RESET;
         settle_cnt = '0;
         skip_cnt = '0;
         for (a = 0; a < AXES; a++) begin
            average_q[a] = '0;
            reference_q[a] = '0;
         end
         reports_due.delete();
         reports_pending = 0;
         mismatch_count = 0;
         samples_seen = 0;
         motion_events = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_GAIN:     gain_reg = csr_pwdata[GAIN_W-1:0];
                  REG_THRESH:   thresh_reg = csr_pwdata[THRESH_W-1:0];
                  REG_INTERVAL: interval_reg = csr_pwdata[INTERVAL_W-1:0];
                  default:      ;
               endcase
            end else begin
               case (csr_paddr[3:2])
                  REG_GAIN:
                     if (csr_prdata !== CSR_DATA_W'(gain_reg))
                        flag_mismatch("smoothing_gain readback", gain_reg, csr_prdata);
                  REG_THRESH:
                     if (csr_prdata !== CSR_DATA_W'(thresh_reg))
                        flag_mismatch("motion_threshold readback", thresh_reg, csr_prdata);
                  REG_INTERVAL:
                     if (csr_prdata !== CSR_DATA_W'(interval_reg))
                        flag_mismatch("check_interval readback", interval_reg, csr_prdata);
                  default: ;
               endcase
            end
         end

         // The response leaves before a request taken in the same cycle joins.
         if (rsp_tvalid && rsp_tready) begin
            if (reports_due.size() == 0) begin
               flag_mismatch("response without a pending request", 0, rsp_tdata);
            end else begin
               due = reports_due.pop_front();
               if (rsp_tuser !== due.found)
                  flag_mismatch("motion_found", due.found, rsp_tuser);
               if (rsp_tdata !== 24'(due.magnitude))
                  flag_mismatch("motion_magnitude", due.magnitude, rsp_tdata);
               if (due.found) motion_events++;
            end
         end

         if (req_tvalid && req_tready) begin
            reports_due.push_back(advance_detector(req_tdata));
            samples_seen++;
         end
         reports_pending = reports_due.size();
      end
   end

endmodule

// ----- test/tb_motion_detect_ema_unit.sv -----
`timescale 1ns / 100ps
// Top of the motion detector bench: clock, reset, request and response
// traffic, register programming and the final verdict. Uses mde_pkg and mde_checker.
module tb_motion_detect_ema_unit;
   import mde_pkg::*;

   localparam int SETTLE_ITEMS = 16;

   // Index past the end of the register list; writes there must be ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // Stretch of the one long receiver stall, and the number of responses
   // taken before it starts.
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AFTER  = 400;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 120;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;   // motion_magnitude [16:0], zero fill [23:17]
   logic                  rsp_tuser;   // motion_found [0]
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int reports_pending;
   int mismatch_count;
   int samples_seen;
   int motion_events;

   // Resting position of the simulated sensor. Most samples jitter around
   // it, so the average settles; a move of the rest point is what the
   // detector should catch.
   logic signed [15:0] rest_pos [AXES];
   int                 noise_span;
   // While set, neither side inserts idle cycles.
   logic               quiet_phase;
   int                 settings_used;

   motion_detect_ema_unit #(
      .SETTLE_ITEMS (SETTLE_ITEMS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mde_checker #(
      .SETTLE_ITEMS (SETTLE_ITEMS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .reports_pending (reports_pending),
      .mismatch_count  (mismatch_count),
      .samples_seen    (samples_seen),
      .motion_events   (motion_events)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes. The longest correct run
   // is far below this even with every gap at its maximum.
   initial begin
      #10_000_000;
      $display("Run stopped by the timeout");
      $display("Mismatches found");
      $finish;
   end

   // Idle length for either side: mostly none or a few cycles, now and then
   // a long pause.
   function automatic int idle_cycles();
      int roll;
      if (quiet_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Corner values of a sample field, rotated across the axes so that each
   // axis sees each of them during the directed part.
   function automatic logic [47:0] corner_sample(input int n);
      logic [15:0] corner [4];
      logic [47:0] s;
      int          a;
      corner[0] = 16'h7FFF;
      corner[1] = 16'h8000;
      corner[2] = 16'h0000;
      corner[3] = 16'hFFFF;
      for (a = 0; a < AXES; a++) s[16*a +: 16] = corner[(n + a) % 4];
      return s;
   endfunction

   // One random sample. Most are the rest position plus noise; some move
   // the rest position, some hit the field extremes and a few are pure noise.
   function automatic logic [47:0] make_sample();
      logic [47:0] s;
      int          roll;
      int          a;
      int          v;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         for (a = 0; a < AXES; a++) rest_pos[a] = 16'($urandom);
      end
      if (roll >= 95) begin
         s = {16'($urandom), 32'($urandom)};
         return s;
      end
      for (a = 0; a < AXES; a++) begin
         if (roll >= 91) begin
            v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
         end else begin
            v = int'(rest_pos[a]) + int'($urandom_range(0, 2 * noise_span)) - noise_span;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
         end
         s[16*a +: 16] = v[15:0];
      end
      return s;
   endfunction

   // One APB transfer: setup phase, access phase, then an idle phase with psel low so
   // that back-to-back transfers never assign psel twice in one step.
   task automatic csr_access(input logic write_en, input logic [1:0] index,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write_en;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_back_all();
      csr_access(1'b0, REG_GAIN, '0);
      csr_access(1'b0, REG_THRESH, '0);
      csr_access(1'b0, REG_INTERVAL, '0);
   endtask

   // Programs all three registers. The bits above each register's width
   // carry junk, which the block must drop.
   task automatic apply_settings(input logic [GAIN_W-1:0] gain,
                                 input logic [THRESH_W-1:0] thresh,
                                 input logic [INTERVAL_W-1:0] interval);
      csr_access(1'b1, REG_GAIN,
                 (CSR_DATA_W'($urandom) << GAIN_W) | CSR_DATA_W'(gain));
      csr_access(1'b1, REG_THRESH,
                 (CSR_DATA_W'($urandom) << THRESH_W) | CSR_DATA_W'(thresh));
      csr_access(1'b1, REG_INTERVAL,
                 (CSR_DATA_W'($urandom) << INTERVAL_W) | CSR_DATA_W'(interval));
      read_back_all();
      settings_used++;
   endtask

   // Offers one request and returns on the falling edge after it was taken.
   // Back-to-back requests keep tvalid high without touching it.
   task automatic send_request(input logic [47:0] data);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Lowers the request valid and waits for every predicted report to come
   // back, so the block is idle and may be reprogrammed.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
   endtask

   // Response side: random backpressure, plus one long stall once enough
   // responses went through. During that stall the sender keeps offering
   // requests, so the block fills and drops req_tready.
   initial begin : rsp_sink
      int  taken;
      int  hold;
      logic stall_done;
      taken = 0;
      stall_done = 1'b0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (!stall_done && taken >= HOLD_AFTER) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int                    phase;
      int                    n;
      logic [GAIN_W-1:0]     gain;
      logic [THRESH_W-1:0]   thresh;
      logic [INTERVAL_W-1:0] interval;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet_phase = 1'b0;
      noise_span = 100;
      settings_used = 0;
      for (n = 0; n < AXES; n++) rest_pos[n] = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values first, then a write past the register list that must
      // leave everything unchanged.
      read_back_all();
      csr_access(1'b1, REG_UNUSED, $urandom);
      read_back_all();

      // Directed part. With a gain of one the average follows each sample,
      // and a zero threshold turns any difference into a detection. Sixteen
      // rotating corner samples settle the reference, the full negative
      // sample then trips the detector, and the remaining items show the
      // reload from the first sample after re-arming and a new settle.
      apply_settings(GAIN_ONE, '0, '0);
      for (n = 0; n < SETTLE_ITEMS; n++) send_request(corner_sample(n));
      send_request({3{16'h8000}});
      send_request({3{16'h7FFF}});
      send_request(48'h0000_FFFF_0000);
      send_request(corner_sample(2));
      drain();

      // Random part. The phase order matters in one place: the long check
      // interval lets the skip counter climb, and the next phase lowers the
      // interval below it, which must force an immediate check.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               gain = GAIN_ONE;
               thresh = THRESH_W'(500);
               interval = '0;
            end
            1: begin
               // Gain above one must behave as exactly one.
               gain = GAIN_W'(131071);
               thresh = '0;
               interval = INTERVAL_W'(3);
            end
            2: begin
               // Zero gain freezes the average after its first load.
               gain = '0;
               thresh = '0;
               interval = '0;
            end
            3: begin
               gain = GAIN_W'($urandom_range(1, 65535));
               thresh = THRESH_W'($urandom_range(0, 2000));
               interval = INTERVAL_W'(255);
            end
            4: begin
               gain = GAIN_W'($urandom_range(20000, 65535));
               thresh = THRESH_W'($urandom_range(0, 3000));
               interval = INTERVAL_W'(2);
            end
            5: begin
               gain = GAIN_RESET;
               thresh = THRESH_RESET;
               interval = INTERVAL_RESET;
            end
            6: begin
               // The largest threshold lies above any reachable magnitude.
               gain = GAIN_W'($urandom_range(65537, 131071));
               thresh = THRESH_W'(131071);
               interval = INTERVAL_W'($urandom_range(0, 255));
            end
            default: begin
               gain = GAIN_W'($urandom_range(0, 65536));
               thresh = THRESH_W'($urandom_range(0, 4000));
               interval = INTERVAL_W'($urandom_range(0, 6));
            end
         endcase
         quiet_phase = (phase % 4 == 3);
         noise_span = $urandom_range(0, 400);
         apply_settings(gain, thresh, interval);
         for (n = 0; n < PHASE_ITEMS; n++) send_request(make_sample());
         drain();
      end

      // Everything predicted has arrived; leave room for a stray response
      // beyond the slowest request latency of the block.
      quiet_phase = 1'b0;
      repeat (40) @(negedge clock);

      $display("Covered %0d samples under %0d register settings with %0d motion reports,",
               samples_seen, settings_used, motion_events);
      $display("including one long response stall of %0d cycles.", LONG_HOLD);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
